FILE: src/quaternion_to_euler_angles_core_macros.svh
// Assertion macros used by the core's top-level RTL file.
`ifndef QUATERNION_TO_EULER_ANGLES_CORE_MACROS_SVH
`define QUATERNION_TO_EULER_ANGLES_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define Q2E_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define Q2E_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define Q2E_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define Q2E_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: src/q2e_pkg.sv
package q2e_pkg;

    localparam int DEF_FRACTION_BITS = 14;
    localparam int DEF_ANGLE_BITS    = 16;

    localparam int ATAN_STEPS = 30;
    localparam int NORM_STEPS = 6;
    localparam int SQRT_STEPS = 32;

    // prep + normalise + vectoring + final add
    localparam int LAT_ATAN = 1 + NORM_STEPS + ATAN_STEPS + 1;
    localparam int LAT_SQRT = SQRT_STEPS;

    typedef logic signed [63:0] t_wide;
    typedef logic [31:0]        t_angle;

    localparam t_angle QTR_POS = 32'h4000_0000;
    localparam t_angle QTR_NEG = 32'hC000_0000;

    // atan(2^-i) in units of 2^32 per turn
    localparam t_angle ATAN_TAB [ATAN_STEPS] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
    };

endpackage

FILE: src/q2e_isqrt.sv
module q2e_isqrt (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [63:0]     i_radicand,
    output q2e_pkg::t_angle o_root
);
    import q2e_pkg::*;

    logic [63:0] r_v [SQRT_STEPS];
    logic [63:0] r_r [SQRT_STEPS];

    // one result bit per stage, trial bit 4^(31-j)
    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
        logic [63:0] v_in, r_in, trial;
        logic [63:0] n_v, n_r;

        if (j == 0) begin : g_first
            assign v_in = i_radicand;
            assign r_in = '0;
        end else begin : g_rest
            assign v_in = r_v[j-1];
            assign r_in = r_r[j-1];
        end

        assign trial = r_in + BIT;

        always_comb begin
            if (v_in >= trial) begin
                n_v = v_in - trial;
                n_r = (r_in >> 1) + BIT;
            end else begin
                n_v = v_in;
                n_r = r_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[j] <= n_v;
                r_r[j] <= n_r;
            end
        end
    end

    assign o_root = r_r[SQRT_STEPS-1][31:0];

endmodule

FILE: src/q2e_atan2.sv
module q2e_atan2 (
    input  logic            i_clk,
    input  logic            i_en,
    input  q2e_pkg::t_wide  i_y,
    input  q2e_pkg::t_wide  i_x,
    output q2e_pkg::t_angle o_angle
);
    import q2e_pkg::*;

    // quadrant fold
    logic        n0_zero, n0_neg;
    t_wide       n0_x, n0_y;
    logic [63:0] ax, ay;
    logic        r0_zero, r0_neg;
    t_wide       r0_x, r0_y;
    logic [63:0] r0_m;

    always_comb begin
        n0_zero = (i_x == '0) && (i_y == '0);
        n0_neg  = i_x < 0;
        n0_x    = n0_neg ? -i_x : i_x;
        n0_y    = n0_neg ? -i_y : i_y;
        ax      = n0_x < 0 ? 64'(-n0_x) : 64'(n0_x);
        ay      = n0_y < 0 ? 64'(-n0_y) : 64'(n0_y);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_zero <= n0_zero;
            r0_neg  <= n0_neg;
            r0_x    <= n0_x;
            r0_y    <= n0_y;
            r0_m    <= (ax > ay) ? ax : ay;
        end
    end

    // normalise: larger magnitude into [2^58, 2^59), binary steps 32..1
    t_wide       r_nx [NORM_STEPS];
    t_wide       r_ny [NORM_STEPS];
    logic [63:0] r_nm [NORM_STEPS];
    logic        r_nzero [NORM_STEPS];
    logic        r_nneg  [NORM_STEPS];

    for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
        localparam int          SH  = 32 >> k;
        localparam logic [63:0] LIM = 64'd1 << (59 - SH);
        t_wide       x_in, y_in;
        logic [63:0] m_in;
        logic        z_in, g_in, take;

        if (k == 0) begin : g_first
            assign x_in = r0_x;
            assign y_in = r0_y;
            assign m_in = r0_m;
            assign z_in = r0_zero;
            assign g_in = r0_neg;
        end else begin : g_rest
            assign x_in = r_nx[k-1];
            assign y_in = r_ny[k-1];
            assign m_in = r_nm[k-1];
            assign z_in = r_nzero[k-1];
            assign g_in = r_nneg[k-1];
        end

        assign take = m_in < LIM;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_nx[k]    <= take ? (x_in <<< SH) : x_in;
                r_ny[k]    <= take ? (y_in <<< SH) : y_in;
                r_nm[k]    <= take ? (m_in << SH) : m_in;
                r_nzero[k] <= z_in;
                r_nneg[k]  <= g_in;
            end
        end
    end

    // vectoring iterations, drive y towards zero
    t_wide  r_cx [ATAN_STEPS];
    t_wide  r_cy [ATAN_STEPS];
    t_angle r_cz [ATAN_STEPS];
    logic   r_czero [ATAN_STEPS];
    logic   r_cneg  [ATAN_STEPS];

    for (genvar i = 0; i < ATAN_STEPS; i++) begin : g_cordic
        t_wide  x_in, y_in, dx, dy;
        t_angle z_in;
        logic   z0_in, g_in;

        if (i == 0) begin : g_first
            assign x_in  = r_nx[NORM_STEPS-1];
            assign y_in  = r_ny[NORM_STEPS-1];
            assign z_in  = '0;
            assign z0_in = r_nzero[NORM_STEPS-1];
            assign g_in  = r_nneg[NORM_STEPS-1];
        end else begin : g_rest
            assign x_in  = r_cx[i-1];
            assign y_in  = r_cy[i-1];
            assign z_in  = r_cz[i-1];
            assign z0_in = r_czero[i-1];
            assign g_in  = r_cneg[i-1];
        end

        assign dx = y_in >>> i;
        assign dy = x_in >>> i;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (y_in >= 0) begin
                    r_cx[i] <= x_in + dx;
                    r_cy[i] <= y_in - dy;
                    r_cz[i] <= z_in + ATAN_TAB[i];
                end else begin
                    r_cx[i] <= x_in - dx;
                    r_cy[i] <= y_in + dy;
                    r_cz[i] <= z_in - ATAN_TAB[i];
                end
                r_czero[i] <= z0_in;
                r_cneg[i]  <= g_in;
            end
        end
    end

    t_angle r_angle;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_angle <= r_czero[ATAN_STEPS-1] ? '0
                     : r_cz[ATAN_STEPS-1] + {r_cneg[ATAN_STEPS-1], 31'd0};
        end
    end

    assign o_angle = r_angle;

endmodule

FILE: src/quaternion_to_euler_angles_core.sv
// Channel  Dir  Ports                          Beat
// s        in   i_s_tvalid/o_s_tready/i_s_tdata quaternion w, x, y, z
// m        out  o_m_tvalid/i_m_tready/o_m_tdata roll, pitch, yaw
//
// One beat per cycle in, one per cycle out unless the m side stalls. A result
// passes 76 register stages after its input beat is taken. The depth is set by
// the 32-step square root and the 38-stage CORDIC arctangent in series on pitch.
// Synchronous active-low reset clears only the valid line; no clearing pass.
// A stall on the m side freezes the whole pipe: nothing is lost or repeated,
// and bubbles are still taken in while the output beat is not yet waiting.
`include "quaternion_to_euler_angles_core_macros.svh"

module quaternion_to_euler_angles_core #(
    parameter int FRACTION_BITS = q2e_pkg::DEF_FRACTION_BITS,
    parameter int ANGLE_BITS    = q2e_pkg::DEF_ANGLE_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,  // quat_w, quat_x, quat_y, quat_z
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata   // roll_angle, pitch_angle, yaw_angle
);
    import q2e_pkg::*;

    localparam int    TWO_F = 2 * FRACTION_BITS;
    localparam t_wide ONE   = t_wide'(64'd1 << TWO_F);
    // sine term brought to 30 fraction bits
    localparam int    ADJ_R = (TWO_F >= 30) ? TWO_F - 30 : 0;
    localparam int    ADJ_L = (TWO_F < 30) ? 30 - TWO_F : 0;

    // stage map: 1 products, 2 sums, 3-5 pitch prep, isqrt, atan2, output
    localparam int S_DLY     = 2 + LAT_SQRT;             // stage 3 -> isqrt out
    localparam int RY_DLY    = 3 + LAT_SQRT;             // roll/yaw catch-up
    localparam int CL_DLY    = 2 + LAT_SQRT + LAT_ATAN;  // clamp flag
    localparam int LAT_TOTAL = 5 + LAT_SQRT + LAT_ATAN + 1;

    // angle rounding, half up
    localparam int          ASH = 32 - ANGLE_BITS;
    localparam logic [32:0] RND = (ASH > 0) ? (33'd1 << ((ASH > 0) ? ASH - 1 : 0)) : 33'd0;
    localparam int          FW  = (ANGLE_BITS > 16) ? ANGLE_BITS : 16;

    function automatic logic [15:0] to_field(input t_angle a);
        logic [32:0]                  sum;
        logic [32:0]                  shd;
        logic signed [ANGLE_BITS-1:0] fs;
        logic signed [FW-1:0]         fe;
        sum = {1'b0, a} + RND;
        shd = sum >> ASH;
        fs  = shd[ANGLE_BITS-1:0];
        fe  = FW'(fs);
        return fe[15:0];
    endfunction

    logic en;
    logic r_valid [1:LAT_TOTAL];

    // whole pipe moves unless a finished beat is held
    assign en         = !r_valid[LAT_TOTAL] || i_m_tready;
    assign o_s_tready = en;
    assign o_m_tvalid = r_valid[LAT_TOTAL];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= LAT_TOTAL; k++) r_valid[k] <= 1'b0;
        end else if (en) begin
            r_valid[1] <= i_s_tvalid;
            for (int k = 2; k <= LAT_TOTAL; k++) r_valid[k] <= r_valid[k-1];
        end
    end

    // stage 1: the nine products
    logic signed [15:0] qw, qx, qy, qz;
    logic signed [31:0] r1_wx, r1_yz, r1_xx, r1_yy, r1_wy, r1_zx, r1_wz, r1_xy, r1_zz;

    assign qw = i_s_tdata[15:0];
    assign qx = i_s_tdata[31:16];
    assign qy = i_s_tdata[47:32];
    assign qz = i_s_tdata[63:48];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_wx <= qw * qx;
            r1_yz <= qy * qz;
            r1_xx <= qx * qx;
            r1_yy <= qy * qy;
            r1_wy <= qw * qy;
            r1_zx <= qz * qx;
            r1_wz <= qw * qz;
            r1_xy <= qx * qy;
            r1_zz <= qz * qz;
        end
    end

    // stage 2: sine and cosine terms at scale 2^(2F)
    t_wide r2_sr, r2_cr, r2_sp, r2_sy, r2_cy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_sr <= (64'(r1_wx) + 64'(r1_yz)) <<< 1;
            r2_cr <= ONE - ((64'(r1_xx) + 64'(r1_yy)) <<< 1);
            r2_sp <= (64'(r1_wy) - 64'(r1_zx)) <<< 1;
            r2_sy <= (64'(r1_wz) + 64'(r1_xy)) <<< 1;
            r2_cy <= ONE - ((64'(r1_yy) + 64'(r1_zz)) <<< 1);
        end
    end

    // stage 3: |sp|, limit check, rescale
    logic [63:0]        sp_mag, sp_adj;
    logic               n3_clamp, n3_neg;
    logic [29:0]        n3_madj;
    logic [29:0]        r3_madj;
    logic signed [30:0] r3_s;
    logic               r3_clamp, r3_neg;

    always_comb begin
        n3_neg   = r2_sp < 0;
        sp_mag   = n3_neg ? 64'(-r2_sp) : 64'(r2_sp);
        n3_clamp = sp_mag >= 64'(ONE);
        sp_adj   = (sp_mag >> ADJ_R) << ADJ_L;
        n3_madj  = n3_clamp ? '0 : sp_adj[29:0];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_madj  <= n3_madj;
            r3_s     <= n3_neg ? -$signed({1'b0, n3_madj}) : $signed({1'b0, n3_madj});
            r3_clamp <= n3_clamp;
            r3_neg   <= n3_neg;
        end
    end

    // stages 4-5: cosine squared = 1 - s^2 at 60 fraction bits
    logic [59:0] r4_sq;
    logic [63:0] r5_v;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_sq <= r3_madj * r3_madj;
            r5_v  <= (64'd1 << 60) - 64'(r4_sq);
        end
    end

    t_angle w_root;

    q2e_isqrt u_sqrt (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_radicand (r5_v),
        .o_root     (w_root)
    );

    // sine term waits for its cosine
    logic signed [30:0] r_s_dly [S_DLY];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s_dly[0] <= r3_s;
            for (int k = 1; k < S_DLY; k++) r_s_dly[k] <= r_s_dly[k-1];
        end
    end

    t_angle w_pitch, w_roll, w_yaw;

    q2e_atan2 u_atan_pitch (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (64'(r_s_dly[S_DLY-1])),
        .i_x     ({32'd0, w_root}),
        .o_angle (w_pitch)
    );

    q2e_atan2 u_atan_roll (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (r2_sr),
        .i_x     (r2_cr),
        .o_angle (w_roll)
    );

    q2e_atan2 u_atan_yaw (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (r2_sy),
        .i_x     (r2_cy),
        .o_angle (w_yaw)
    );

    // roll/yaw catch up with pitch; clamp flag rides alongside
    logic [63:0] r_ry_dly [RY_DLY];
    logic [1:0]  r_cl_dly [CL_DLY];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ry_dly[0] <= {w_yaw, w_roll};
            for (int k = 1; k < RY_DLY; k++) r_ry_dly[k] <= r_ry_dly[k-1];
            r_cl_dly[0] <= {r3_clamp, r3_neg};
            for (int k = 1; k < CL_DLY; k++) r_cl_dly[k] <= r_cl_dly[k-1];
        end
    end

    // output register
    t_angle      pitch_sel;
    logic [47:0] r_out;

    always_comb begin
        if (r_cl_dly[CL_DLY-1][1]) begin
            pitch_sel = r_cl_dly[CL_DLY-1][0] ? QTR_NEG : QTR_POS;
        end else begin
            pitch_sel = w_pitch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= {to_field(r_ry_dly[RY_DLY-1][63:32]),
                      to_field(pitch_sel),
                      to_field(r_ry_dly[RY_DLY-1][31:0])};
        end
    end

    assign o_m_tdata = r_out;

    logic signed [15:0] pitch_out;
    assign pitch_out = o_m_tdata[31:16];

    `Q2E_ASSERT_IMPL(a_ready_when_empty, i_clk, i_rst_n, !o_m_tvalid, o_s_tready)
    `Q2E_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_s_tvalid && o_s_tready, r_valid[1])
    `Q2E_ASSERT_IMPL(a_pitch_range, i_clk, i_rst_n, o_m_tvalid && (ANGLE_BITS == 16), (pitch_out <= 16384) && (pitch_out >= -16384))

endmodule
